### rtl/srb_pkg.sv
// srb_pkg: shared types and constants for the shape rasteriser.
// Depends on nothing; imported by every rtl module.
`timescale 1ns / 1ps
package srb_pkg;
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 64;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0, MODE_LINE = 3'd1, MODE_RECT = 3'd2, MODE_CIRCLE = 3'd3,
    MODE_TRI = 3'd4, MODE_READ = 3'd5, MODE_NOP6 = 3'd6, MODE_NOP7 = 3'd7
  } mode_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] ra;
    logic [5:0] ca;
    logic [4:0] rb;
    logic [5:0] cb;
    logic [4:0] rc;
    logic [5:0] cc;
    logic [6:0] rad;
  } cmd_t;
endpackage

### rtl/srb_front.sv
// srb_front: accepts command beats, sorts rectangle corners, queues them.
// Depends on srb_pkg.
`timescale 1ns / 1ps
module srb_front import srb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_cmd,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_cmd
);
  cmd_t       q_r [QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push, pop;

  // sort rectangle corners so the smaller row and column come first
  always_comb begin
    cls = in_cmd;
    if (in_cmd.mode == MODE_RECT) begin
      if (in_cmd.rb < in_cmd.ra) begin
        cls.ra = in_cmd.rb;
        cls.rb = in_cmd.ra;
      end
      if (in_cmd.cb < in_cmd.ca) begin
        cls.ca = in_cmd.cb;
        cls.cb = in_cmd.ca;
      end
    end
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) cnt_r == 2'(QDEPTH) |-> !push;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_cnt_range;
    @(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDEPTH);
  endproperty
  a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

  property p_pop_nonempty;
    @(posedge clk) disable iff (!rst_n) pop |-> cnt_r != 2'd0;
  endproperty
  a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop from empty queue");
endmodule

### rtl/srb_back.sv
// srb_back: draws queued commands into the canvas, one pixel per
// read-modify-write, and holds the result register. Depends on srb_pkg.
`timescale 1ns / 1ps
module srb_back import srb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  logic [5:0]  act_rows,
  input  logic [6:0]  act_cols,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_row_bits,
  output logic [2:0]  out_mode_done
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_SEGSET = 9'b000000100,
    S_SEG    = 9'b000001000,
    S_RING   = 9'b000010000,
    S_PLOT   = 9'b000100000,
    S_READ   = 9'b001000000,
    S_READ2  = 9'b010000000,
    S_DONE   = 9'b100000000
  } st_t;

  st_t         st_r, st_nxt;
  cmd_t        cmd_r;
  logic [63:0] mem [MAX_ROWS];
  logic [63:0] rd_r;
  logic [RW:0] clr_r;            // clearing pass counter / also reset pass
  logic        rst_clr_r;        // reset-time clearing still running
  logic [1:0]  seg_r;            // edge number within a shape
  // Bresenham state (signed, one guard bit beyond coordinates)
  logic signed [7:0] r_r, c_r, re_r, ce_r, dr_r, dc_r, acc_r;
  logic signed [1:0] sr_r, sc_r;
  // midpoint circle state
  logic signed [8:0] p_r, q_r, dec_r;
  logic [2:0]  oct_r;
  // pixel plot pipeline: read row, then or in bit
  logic signed [8:0] pr, pc;
  logic        plot_en;
  logic [RW-1:0] prow_r;
  logic [CW-1:0] pcol_r;
  logic        pv_r;
  logic [6:0]  rlim, clim;
  logic        mem_we;
  logic [RW-1:0] mem_wa;
  logic [63:0] mem_wd, rrow_r;
  logic        out_valid_r;
  logic [63:0] res_bits_r;

  assign rlim = (act_rows > 6'(MAX_ROWS)) ? 7'(MAX_ROWS) : {1'b0, act_rows};
  assign clim = (act_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : act_cols;

  // segment endpoints for the current edge of each shape
  logic signed [7:0] s_r0, s_c0, s_r1, s_c1;
  always_comb begin
    s_r0 = 8'($signed({3'b0, cmd_r.ra})); s_c0 = 8'($signed({2'b0, cmd_r.ca}));
    s_r1 = 8'($signed({3'b0, cmd_r.rb})); s_c1 = 8'($signed({2'b0, cmd_r.cb}));
    if (cmd_r.mode == MODE_RECT) begin
      case (seg_r)
        2'd0: begin s_r1 = s_r0; end
        2'd1: begin s_r0 = s_r1; end
        2'd2: begin s_c1 = s_c0; end
        default: begin s_c0 = s_c1; end
      endcase
    end else if (cmd_r.mode == MODE_TRI) begin
      case (seg_r)
        2'd0: ;
        2'd1: begin
          s_r0 = 8'($signed({3'b0, cmd_r.rb})); s_c0 = 8'($signed({2'b0, cmd_r.cb}));
          s_r1 = 8'($signed({3'b0, cmd_r.rc})); s_c1 = 8'($signed({2'b0, cmd_r.cc}));
        end
        default: begin
          s_r0 = 8'($signed({3'b0, cmd_r.rc})); s_c0 = 8'($signed({2'b0, cmd_r.cc}));
          s_r1 = 8'($signed({3'b0, cmd_r.ra})); s_c1 = 8'($signed({2'b0, cmd_r.ca}));
        end
      endcase
    end
  end

  logic [1:0] last_seg;
  assign last_seg = (cmd_r.mode == MODE_RECT) ? 2'd3 :
                    (cmd_r.mode == MODE_TRI) ? 2'd2 : 2'd0;

  // octant pixel offsets
  logic signed [8:0] cr9, cc9;
  assign cr9 = 9'($signed({4'b0, cmd_r.ra}));
  assign cc9 = 9'($signed({3'b0, cmd_r.ca}));
  always_comb begin
    case (oct_r)
      3'd0: begin pr = cr9 + p_r; pc = cc9 + q_r; end
      3'd1: begin pr = cr9 - p_r; pc = cc9 + q_r; end
      3'd2: begin pr = cr9 + p_r; pc = cc9 - q_r; end
      3'd3: begin pr = cr9 - p_r; pc = cc9 - q_r; end
      3'd4: begin pr = cr9 + q_r; pc = cc9 + p_r; end
      3'd5: begin pr = cr9 - q_r; pc = cc9 + p_r; end
      3'd6: begin pr = cr9 + q_r; pc = cc9 - p_r; end
      default: begin pr = cr9 - q_r; pc = cc9 - p_r; end
    endcase
    if (st_r == S_SEG) begin
      pr = 9'(r_r);
      pc = 9'(c_r);
    end
    plot_en = ((st_r == S_SEG) || (st_r == S_RING)) && !pr[8] && !pc[8] &&
              (pr < $signed({2'b0, rlim})) && (pc < $signed({2'b0, clim}));
  end

  // Bresenham step
  logic signed [8:0] twice;
  logic seg_end;
  assign twice   = {acc_r, 1'b0};
  assign seg_end = (r_r == re_r) && (c_r == ce_r);

  // stall the plotting while the read-modify-write of the previous pixel
  // still targets the same row (the write lands in the cycle after the read)
  logic hazard;
  assign hazard = pv_r && (prow_r == pr[RW-1:0]) && plot_en;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid && !rst_clr_r) begin
        case (q_cmd.mode)
          MODE_CLEAR: st_nxt = S_CLEAR;
          MODE_LINE, MODE_RECT, MODE_TRI: st_nxt = S_SEGSET;
          MODE_CIRCLE: st_nxt = S_RING;
          MODE_READ: st_nxt = S_READ;
          default: st_nxt = S_DONE;
        endcase
      end
      S_CLEAR: if (clr_r == (RW+1)'(MAX_ROWS - 1)) st_nxt = S_DONE;
      S_SEGSET: st_nxt = S_SEG;
      S_SEG: if (!hazard && seg_end) st_nxt = (seg_r == last_seg) ? S_PLOT : S_SEGSET;
      S_RING: if (!hazard && oct_r == 3'd7 && !(q_r > p_r)) st_nxt = S_PLOT;
      S_PLOT: st_nxt = S_DONE;
      S_READ: st_nxt = S_READ2;
      S_READ2: st_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign q_ready = (st_r == S_IDLE) && !rst_clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      rst_clr_r <= 1'b1;
      clr_r     <= '0;
      pv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pv_r <= plot_en && !hazard;
      if (rst_clr_r || st_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == (RW+1)'(MAX_ROWS - 1)) begin
          rst_clr_r <= 1'b0;
          clr_r     <= '0;
        end
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (st_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cmd_r <= q_cmd;
      seg_r <= 2'd0;
      p_r   <= '0;
      q_r   <= 9'($signed({2'b0, q_cmd.rad}));
      dec_r <= 9'sd1 - 9'($signed({2'b0, q_cmd.rad}));
      oct_r <= 3'd0;
      res_bits_r <= '0;
    end
    if (st_r == S_SEGSET) begin
      r_r  <= s_r0; c_r <= s_c0; re_r <= s_r1; ce_r <= s_c1;
      dc_r <= (s_c1 > s_c0) ? s_c1 - s_c0 : s_c0 - s_c1;
      dr_r <= (s_r1 > s_r0) ? s_r1 - s_r0 : s_r0 - s_r1;
      acc_r <= ((s_c1 > s_c0) ? s_c1 - s_c0 : s_c0 - s_c1) -
               ((s_r1 > s_r0) ? s_r1 - s_r0 : s_r0 - s_r1);
      sc_r <= (s_c1 > s_c0) ? 2'sd1 : (s_c1 < s_c0) ? -2'sd1 : 2'sd0;
      sr_r <= (s_r1 > s_r0) ? 2'sd1 : (s_r1 < s_r0) ? -2'sd1 : 2'sd0;
    end
    if (st_r == S_SEG && !hazard) begin
      if (seg_end) seg_r <= seg_r + 2'd1;
      else begin
        if (twice > -9'(dr_r) && twice < 9'(dc_r)) begin
          acc_r <= acc_r - dr_r + dc_r;
          c_r <= c_r + 8'(sc_r); r_r <= r_r + 8'(sr_r);
        end else if (twice > -9'(dr_r)) begin
          acc_r <= acc_r - dr_r; c_r <= c_r + 8'(sc_r);
        end else if (twice < 9'(dc_r)) begin
          acc_r <= acc_r + dc_r; r_r <= r_r + 8'(sr_r);
        end
      end
    end
    if (st_r == S_RING && !hazard) begin
      oct_r <= oct_r + 3'd1;
      if (oct_r == 3'd7 && q_r > p_r) begin
        if (dec_r < 0) dec_r <= dec_r + {p_r[7:0], 1'b0} + 9'sd3;
        else begin
          dec_r <= dec_r + {p_r[7:0] - q_r[7:0], 1'b0} + 9'sd5;
          q_r   <= q_r - 9'sd1;
        end
        p_r <= p_r + 9'sd1;
      end
    end
    if (st_r == S_READ2) res_bits_r <= ({1'b0, cmd_r.ra} < 6'(MAX_ROWS)) ? rd_r : '0;
    if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_row_bits  <= res_bits_r;
      out_mode_done <= cmd_r.mode;
    end
  end

  // canvas memory: one write and two registered reads (plot row, read row) per cycle
  always_comb begin
    mem_we = 1'b0;
    mem_wa = prow_r;
    mem_wd = rrow_r | (64'd1 << pcol_r);
    if (rst_clr_r || st_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r[RW-1:0];
      mem_wd = '0;
    end else if (pv_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rrow_r <= mem[pr[RW-1:0]];
    rd_r   <= mem[cmd_r.ra];
    prow_r <= pr[RW-1:0];
    pcol_r <= pc[CW-1:0];
  end

  assign out_valid = out_valid_r;

  property p_no_plot_in_clear;
    @(posedge clk) disable iff (!rst_n) rst_clr_r |-> !pv_r;
  endproperty
  a_no_plot_in_clear: assert property (p_no_plot_in_clear) else $error("plot during clear");

  property p_hold_result;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_ready |=> $stable(out_row_bits) && $stable(out_mode_done);
  endproperty
  a_hold_result: assert property (p_hold_result) else $error("result changed while stalled");

  property p_idle_accept;
    @(posedge clk) disable iff (!rst_n) q_ready |-> st_r == S_IDLE;
  endproperty
  a_idle_accept: assert property (p_idle_accept) else $error("accept outside idle");
endmodule

### rtl/shape_rasterizer_bitmap.sv
// Shape rasteriser: 32 x 64 one-bit canvas, line/rectangle/circle/triangle.
// Lines, rectangles and triangles take a set-up step per edge and a step per pixel,
// clipped pixels included; circles plot eight octant points per step; each same-row
// hazard stalls a step. The draw unit handles one command at a time; a two-entry
// command queue decouples input.
// Reset: synchronous, active low; a clearing pass zeroes every canvas row, during
// which commands wait in the queue.
`timescale 1ns / 1ps
module shape_rasterizer_bitmap import srb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_row_a,
  input  logic [5:0]  in_col_a,
  input  logic [4:0]  in_row_b,
  input  logic [5:0]  in_col_b,
  input  logic [4:0]  in_row_c,
  input  logic [5:0]  in_col_c,
  input  logic [6:0]  in_radius,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_row_bits,
  output logic [2:0]  out_mode_done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  cmd_t       in_cmd, q_cmd;
  logic       q_valid, q_ready;
  logic [5:0] rows_r;
  logic [6:0] cols_r;

  // pack the command beat
  assign in_cmd = '{mode: in_mode, ra: in_row_a, ca: in_col_a, rb: in_row_b,
                    cb: in_col_b, rc: in_row_c, cc: in_col_c, rad: in_radius};

  // active window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 6'd25;
      cols_r <= 7'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data[5:0];
        default:  cols_r <= cfg_data;
      endcase
    end
  end

  srb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  srb_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .act_rows(rows_r), .act_cols(cols_r),
    .out_valid, .out_ready, .out_row_bits, .out_mode_done
  );
endmodule
